[hw/rtl/dual_chip_glcd_controller_macros.svh]
// ----------------------------------------------------------------------------
// dual_chip_glcd_controller_macros.svh
// Assertion macros shared by the graphic display controller RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHIP_GLCD_CONTROLLER_MACROS_SVH
`define DUAL_CHIP_GLCD_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DCG_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DCG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dcg_pkg.sv]
// ----------------------------------------------------------------------------
// dcg_pkg
// Constants, instruction codes and shared types of the graphic display
// controller.
// ----------------------------------------------------------------------------
package dcg_pkg;

    // display geometry, fixed by the controller chip
    localparam int DCG_COLUMNS = 64;
    localparam int DCG_PAGES   = 8;
    localparam int DCG_CHIPS   = 2;

    localparam int COL_W  = $clog2(DCG_COLUMNS);
    localparam int PAGE_W = $clog2(DCG_PAGES);
    localparam int LINE_W = 6;

    // instruction codes and masks
    localparam logic [7:0] INSTR_DISP_OFF  = 8'h3E;
    localparam logic [7:0] INSTR_DISP_ON   = 8'h3F;
    localparam logic [7:0] INSTR_TOP_MASK  = 8'hC0;
    localparam logic [7:0] INSTR_COL_CODE  = 8'h40;
    localparam logic [7:0] INSTR_PAGE_MASK = 8'hF8;
    localparam logic [7:0] INSTR_PAGE_CODE = 8'hB8;
    localparam logic [7:0] INSTR_LINE_CODE = 8'hC0;

    // status byte with the display-off flag set
    localparam logic [7:0] STATUS_OFF = 8'h20;
    localparam logic [7:0] STATUS_ON  = 8'h00;

    typedef enum logic [2:0] {
        INSTR_NONE,
        INSTR_DISPLAY,
        INSTR_COLUMN,
        INSTR_PAGE,
        INSTR_LINE
    } dcg_instr_t;

    // one accepted bus access, as seen by the register bank
    typedef struct packed {
        logic       fire;
        logic       rd;
        logic       chip;
        logic       data;
        logic [7:0] wdata;
    } dcg_access_t;

    // instruction decode, first match wins
    function automatic dcg_instr_t dcg_decode(input logic [7:0] b);
        dcg_instr_t res;
        priority if (b == INSTR_DISP_OFF || b == INSTR_DISP_ON)
            res = INSTR_DISPLAY;
        else if ((b & INSTR_TOP_MASK) == INSTR_COL_CODE)
            res = INSTR_COLUMN;
        else if ((b & INSTR_PAGE_MASK) == INSTR_PAGE_CODE)
            res = INSTR_PAGE;
        else if ((b & INSTR_TOP_MASK) == INSTR_LINE_CODE)
            res = INSTR_LINE;
        else
            res = INSTR_NONE;
        return res;
    endfunction

endpackage

[hw/rtl/dcg_ifs.sv]
// ----------------------------------------------------------------------------
// dcg_ifs
// Valid/ready channels of the controller: bus access in, read word out.
// ----------------------------------------------------------------------------
interface dcg_cmd_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic       chip;
    logic       reg_select;
    logic [7:0] wr_data;

    modport source (output valid, op, chip, reg_select, wr_data, input ready);
    modport sink   (input valid, op, chip, reg_select, wr_data, output ready);
endinterface

interface dcg_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] rd_data;

    modport source (output valid, rd_data, input ready);
    modport sink   (input valid, rd_data, output ready);
endinterface

[hw/rtl/dual_chip_glcd_controller.sv]
// ----------------------------------------------------------------------------
// dual_chip_glcd_controller
// Bus-level model of a two-chip graphic display controller.
// ----------------------------------------------------------------------------
// One bus access is taken per clock cycle; a read returns its word in a
// result register in the following cycle, and the next access is taken in that
// same cycle as long as the result side is not stalled. Behind the single-port
// display RAM and its registered read, a data read hands out the chip's output
// latch, and the RAM word read with it then reloads the latch, the word being
// forwarded to a following read of the same chip. After reset the display RAM
// is cleared by a sweep of CHIPS*512 entries (1024 with two chips) during which
// no access is taken. A data read returns the latch contents, so the first
// read after setting an address is a dummy read. Status reads return 0x20
// when the display is off, 0x00 when on; the start line is stored only.
// ----------------------------------------------------------------------------
`include "dual_chip_glcd_controller_macros.svh"

module dual_chip_glcd_controller
    import dcg_pkg::*;
#(
    parameter int CHIPS = DCG_CHIPS
)(
    input  logic       clk,
    input  logic       rst_n,
    dcg_cmd_if.sink    cmd,
    dcg_rsp_if.source  rsp
);

    localparam int ADDR_W = $clog2(CHIPS * DCG_PAGES * DCG_COLUMNS);

    logic              accept;
    logic              present;
    logic              clr_busy;
    dcg_access_t       acc;
    logic [PAGE_W-1:0] sel_page;
    logic [COL_W-1:0]  sel_col;
    logic [7:0]        sel_latch;
    logic              sel_disp_on;
    logic [7:0]        ram_rdata;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic              ram_re;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        rd_data_reg;
    logic [7:0]        rd_data_next;

    // handshake
    assign cmd.ready = !clr_busy && (!out_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;
    assign present   = int'(cmd.chip) < CHIPS;

    assign acc.fire  = accept && present;
    assign acc.rd    = cmd.op;
    assign acc.chip  = cmd.chip;
    assign acc.data  = cmd.reg_select;
    assign acc.wdata = cmd.wr_data;

    dcg_chip_regs #(
        .CHIPS (CHIPS)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .ram_rdata   (ram_rdata),
        .sel_page    (sel_page),
        .sel_col     (sel_col),
        .sel_latch   (sel_latch),
        .sel_disp_on (sel_disp_on)
    );

    // display RAM access at the selected chip's page and column
    assign ram_addr = ADDR_W'({cmd.chip, sel_page, sel_col});
    assign ram_we   = acc.fire && !cmd.op && cmd.reg_select;
    assign ram_re   = acc.fire && cmd.op && cmd.reg_select;

    dcg_pixel_ram #(
        .CHIPS (CHIPS)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (ram_we),
        .re       (ram_re),
        .addr     (ram_addr),
        .wdata    (cmd.wr_data),
        .rdata    (ram_rdata),
        .clr_busy (clr_busy)
    );

    // read word select and result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        rd_data_next   = rd_data_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (accept && cmd.op)
        begin
            out_valid_next = 1'b1;
            priority if (!present)
                rd_data_next = 8'h00;
            else if (cmd.reg_select)
                rd_data_next = sel_latch;
            else
                rd_data_next = sel_disp_on ? STATUS_ON : STATUS_OFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rd_data_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.rd_data = rd_data_reg;

    // checks
    `DCG_ASSERT_SAME(a_no_access_in_clear, clk, rst_n, clr_busy, !cmd.ready, "access taken during RAM clear")
    `DCG_ASSERT_NEXT(a_read_gives_word, clk, rst_n, accept && cmd.op, rsp.valid, "read accepted without a result")
    `DCG_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, rsp.valid && !rsp.ready, !cmd.ready, "input taken while result stalled")
    `DCG_ASSERT_NEXT(a_write_no_word, clk, rst_n, accept && !cmd.op && !rsp.valid, !rsp.valid, "write produced a result")

endmodule

[hw/rtl/dcg_pixel_ram.sv]
// ----------------------------------------------------------------------------
// dcg_pixel_ram
// Display RAM of all chips, one write or one read a cycle, registered read
// data, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module dcg_pixel_ram
    import dcg_pkg::*;
#(
    parameter int CHIPS = DCG_CHIPS
)(
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              we,
    input  logic                                              re,
    input  logic [$clog2(CHIPS*DCG_PAGES*DCG_COLUMNS)-1:0]    addr,
    input  logic [7:0]                                        wdata,
    output logic [7:0]                                        rdata,
    output logic                                              clr_busy
);

    localparam int DEPTH  = CHIPS * DCG_PAGES * DCG_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic              clr_busy_reg;
    logic              clr_busy_next;

    // clearing sweep, one entry a cycle
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // memory array
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_addr_reg] <= 8'h00;
        else if (we)
            mem[addr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

endmodule

[hw/rtl/dcg_chip_regs.sv]
// ----------------------------------------------------------------------------
// dcg_chip_regs
// Per-chip column, page, start line, display flag and output latch, with
// instruction decode and the latch reload from display RAM.
// ----------------------------------------------------------------------------
module dcg_chip_regs
    import dcg_pkg::*;
#(
    parameter int CHIPS = DCG_CHIPS
)(
    input  logic              clk,
    input  logic              rst_n,
    input  dcg_access_t       acc,
    input  logic [7:0]        ram_rdata,
    output logic [PAGE_W-1:0] sel_page,
    output logic [COL_W-1:0]  sel_col,
    output logic [7:0]        sel_latch,
    output logic              sel_disp_on
);

    localparam int IDX_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;

    logic [COL_W-1:0]  col_reg   [CHIPS];
    logic [PAGE_W-1:0] page_reg  [CHIPS];
    logic [LINE_W-1:0] line_reg  [CHIPS];
    logic              disp_reg  [CHIPS];
    logic [7:0]        latch_reg [CHIPS];
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;

    logic [IDX_W-1:0]  acc_idx;
    dcg_instr_t        instr;

    assign acc_idx = IDX_W'(acc.chip);
    assign instr   = dcg_decode(acc.wdata);

    // selected chip view, latch forwarded from a reload still in flight
    always_comb
    begin
        sel_page    = '0;
        sel_col     = '0;
        sel_latch   = '0;
        sel_disp_on = 1'b0;
        for (int k = 0; k < CHIPS; k++)
        begin
            if (acc_idx == IDX_W'(k))
            begin
                sel_page    = page_reg[k];
                sel_col     = col_reg[k];
                sel_disp_on = disp_reg[k];
                if (pend_reg && pend_idx_reg == IDX_W'(k))
                    sel_latch = ram_rdata;
                else
                    sel_latch = latch_reg[k];
            end
        end
    end

    // register bank update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHIPS; k++)
            begin
                col_reg[k]   <= '0;
                page_reg[k]  <= '0;
                line_reg[k]  <= '0;
                disp_reg[k]  <= 1'b0;
                latch_reg[k] <= '0;
            end
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < CHIPS; k++)
            begin
                // latch reload from the registered RAM word, flagged by pend_reg after the data read
                if (pend_reg && pend_idx_reg == IDX_W'(k))
                    latch_reg[k] <= ram_rdata;
                if (acc.fire && acc_idx == IDX_W'(k))
                begin
                    if (acc.data)
                        col_reg[k] <= col_reg[k] + 1'b1;
                    else if (!acc.rd)
                    begin
                        unique case (instr)
                            INSTR_DISPLAY: disp_reg[k] <= acc.wdata[0];
                            INSTR_COLUMN:  col_reg[k]  <= acc.wdata[COL_W-1:0];
                            INSTR_PAGE:    page_reg[k] <= acc.wdata[PAGE_W-1:0];
                            INSTR_LINE:    line_reg[k] <= acc.wdata[LINE_W-1:0];
                            INSTR_NONE:    ;
                            default:       ;
                        endcase
                    end
                end
            end
            pend_reg     <= acc.fire && acc.rd && acc.data;
            pend_idx_reg <= acc_idx;
        end
    end

endmodule

[dv/dcg_tb_pkg.sv]
// ----------------------------------------------------------------------------
// dcg_tb_pkg
// Bus access codes shared by the stimulus and the checker of the graphic
// display controller testbench.
// ----------------------------------------------------------------------------
package dcg_tb_pkg;

    // direction of a bus access
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // port addressed by a bus access
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

endpackage

[dv/glcd_access_checker.sv]
// ----------------------------------------------------------------------------
// glcd_access_checker
// Watches the access and read channels of the display controller, tracks
// the display state of both chips and compares every read word with the
// byte the state predicts.
// ----------------------------------------------------------------------------
module glcd_access_checker
    import dcg_pkg::*;
    import dcg_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dcg_cmd_if   cmd,
    dcg_rsp_if   rsp,
    output int   mismatches,
    output int   words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAM_DEPTH = DCG_CHIPS * DCG_PAGES * DCG_COLUMNS;

    // display state per chip
    logic [7:0]        pixel_mem [RAM_DEPTH];
    logic [COL_W-1:0]  col_cnt   [DCG_CHIPS];
    logic [PAGE_W-1:0] page_reg  [DCG_CHIPS];
    logic [LINE_W-1:0] line_reg  [DCG_CHIPS];
    logic              disp_on   [DCG_CHIPS];
    logic [7:0]        out_latch [DCG_CHIPS];

    // read words still to come, oldest first
    logic [7:0] rd_word_q [$];

    function automatic int unsigned pixel_addr(input int c);
        return (c * DCG_PAGES + int'(page_reg[c])) * DCG_COLUMNS + int'(col_cnt[c]);
    endfunction

    // apply one bus access to the state, queue the word a read returns
    task automatic predict_access(input logic op, input logic chip, input logic rs,
                                  input logic [7:0] wdata);
        int c;
        c = int'(chip);
        if (c >= DCG_CHIPS)
        begin
            if (op == OP_READ)
                rd_word_q.push_back(8'h00);
        end
        else if (op == OP_WRITE)
        begin
            if (rs == RS_DATA)
            begin
                pixel_mem[pixel_addr(c)] = wdata;
                col_cnt[c] = col_cnt[c] + 1'b1;
            end
            else if (wdata == INSTR_DISP_OFF || wdata == INSTR_DISP_ON)
                disp_on[c] = wdata[0];
            else if ((wdata & INSTR_TOP_MASK) == INSTR_COL_CODE)
                col_cnt[c] = wdata[COL_W-1:0];
            else if ((wdata & INSTR_PAGE_MASK) == INSTR_PAGE_CODE)
                page_reg[c] = wdata[PAGE_W-1:0];
            else if ((wdata & INSTR_TOP_MASK) == INSTR_LINE_CODE)
                line_reg[c] = wdata[LINE_W-1:0];
        end
        else if (rs == RS_DATA)
        begin
            // dummy-read behavior: hand out the latch, then reload it
            rd_word_q.push_back(out_latch[c]);
            out_latch[c] = pixel_mem[pixel_addr(c)];
            col_cnt[c] = col_cnt[c] + 1'b1;
        end
        else
            rd_word_q.push_back(disp_on[c] ? STATUS_ON : STATUS_OFF);
    endtask

    // track accesses and check read words
    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            foreach (pixel_mem[i])
                pixel_mem[i] = '0;
            for (int c = 0; c < DCG_CHIPS; c++)
            begin
                col_cnt[c]   = '0;
                page_reg[c]  = '0;
                line_reg[c]  = '0;
                disp_on[c]   = 1'b0;
                out_latch[c] = '0;
            end
            rd_word_q.delete();
            mismatches = 0;
            words_pending <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                predict_access(cmd.op, cmd.chip, cmd.reg_select, cmd.wr_data);
            if (rsp.valid && rsp.ready)
            begin
                if (rd_word_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: rd_data unexpected word, expected none, actual %02h",
                             $time, rsp.rd_data);
                end
                else
                begin
                    want = rd_word_q.pop_front();
                    if (rsp.rd_data !== want)
                    begin
                        mismatches = mismatches + 1;
                        $display("%0t: rd_data mismatch, expected %02h, actual %02h",
                                 $time, want, rsp.rd_data);
                    end
                end
            end
            words_pending <= rd_word_q.size();
        end
    end

endmodule

[dv/dual_chip_glcd_controller_tb.sv]
// ----------------------------------------------------------------------------
// dual_chip_glcd_controller_tb
// Drives bus accesses into the two-chip display controller under random
// back-pressure and idle gaps, and leaves the read word checking to
// glcd_access_checker. Directed accesses cover status, dummy reads, column
// wrap, start line and unknown codes; random address-then-burst sequences
// follow.
// ----------------------------------------------------------------------------
module dual_chip_glcd_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcg_pkg::*;
    import dcg_tb_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int PHASE_ACCESSES = 334;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   mismatches;
    int   words_pending;

    dcg_cmd_if cmd ();
    dcg_rsp_if rsp ();

    dual_chip_glcd_controller DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    glcd_access_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // read side back-pressure
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= sink_idle_pct);

    // one bus access, held until the access is taken
    task automatic bus_access(input logic op, input logic chip, input logic rs,
                              input logic [7:0] wdata);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid      <= 1'b1;
        cmd.op         <= op;
        cmd.chip       <= chip;
        cmd.reg_select <= rs;
        cmd.wr_data    <= wdata;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly address-then-burst sequences, with status, mode and noise words
    task automatic random_accesses(input int n_words);
        int   sent;
        int   kind;
        int   len;
        logic c;
        logic burst_rd;
        logic mixed;
        sent = 0;
        while (sent < n_words)
        begin
            c    = 1'($urandom_range(1, 0));
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                bus_access(OP_WRITE, c, RS_INSTR, INSTR_PAGE_CODE | 8'($urandom_range(7)));
                bus_access(OP_WRITE, c, RS_INSTR, INSTR_COL_CODE | 8'($urandom_range(63)));
                len      = $urandom_range(8, 1);
                burst_rd = 1'($urandom_range(1, 0));
                mixed    = 1'($urandom_range(1, 0));
                for (int i = 0; i < len; i++)
                begin
                    if (mixed)
                        burst_rd = 1'($urandom_range(1, 0));
                    bus_access(burst_rd ? OP_READ : OP_WRITE, c, RS_DATA, 8'($urandom));
                end
                sent += len + 2;
            end
            else if (kind < 80)
            begin
                bus_access(OP_READ, c, RS_INSTR, 8'($urandom));
                sent++;
            end
            else if (kind < 88)
            begin
                bus_access(OP_WRITE, c, RS_INSTR,
                           $urandom_range(1, 0) ? INSTR_DISP_ON : INSTR_DISP_OFF);
                sent++;
            end
            else if (kind < 93)
            begin
                bus_access(OP_WRITE, c, RS_INSTR, INSTR_LINE_CODE | 8'($urandom_range(63)));
                sent++;
            end
            else
            begin
                // any access at all, unknown codes included
                bus_access(1'($urandom_range(1, 0)), c, 1'($urandom_range(1, 0)),
                           8'($urandom));
                sent++;
            end
        end
    endtask

    // stall watchdog
    initial
    begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
                stall = 0;
            else
                stall++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        cmd.valid      = 1'b0;
        cmd.op         = OP_WRITE;
        cmd.chip       = 1'b0;
        cmd.reg_select = RS_INSTR;
        cmd.wr_data    = '0;
        rsp.ready      = 1'b0;
        src_idle_pct   = 36;
        sink_idle_pct  = 58;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // status and dummy reads straight after reset
        bus_access(OP_READ,  1'b0, RS_INSTR, 8'hFF);
        bus_access(OP_READ,  1'b0, RS_DATA,  8'hFF);
        bus_access(OP_READ,  1'b1, RS_DATA,  8'h00);
        bus_access(OP_WRITE, 1'b0, RS_INSTR, INSTR_DISP_ON);
        bus_access(OP_READ,  1'b0, RS_INSTR, 8'h00);
        bus_access(OP_READ,  1'b1, RS_INSTR, 8'hFF);
        // last page, last column, write across the column wrap
        bus_access(OP_WRITE, 1'b0, RS_INSTR, INSTR_PAGE_CODE | 8'h07);
        bus_access(OP_WRITE, 1'b0, RS_INSTR, INSTR_COL_CODE | 8'h3F);
        bus_access(OP_WRITE, 1'b0, RS_DATA,  8'hFF);
        bus_access(OP_WRITE, 1'b0, RS_DATA,  8'h00);
        // read back across the wrap, dummy read first
        bus_access(OP_WRITE, 1'b0, RS_INSTR, INSTR_COL_CODE | 8'h3F);
        bus_access(OP_READ,  1'b0, RS_DATA,  8'h00);
        bus_access(OP_READ,  1'b0, RS_DATA,  8'hFF);
        bus_access(OP_READ,  1'b0, RS_DATA,  8'h00);
        // start line extremes
        bus_access(OP_WRITE, 1'b1, RS_INSTR, INSTR_LINE_CODE | 8'h3F);
        bus_access(OP_WRITE, 1'b1, RS_INSTR, INSTR_LINE_CODE);
        // unknown instruction codes
        bus_access(OP_WRITE, 1'b0, RS_INSTR, 8'h00);
        bus_access(OP_WRITE, 1'b0, RS_INSTR, 8'hB7);
        bus_access(OP_WRITE, 1'b1, RS_INSTR, 8'h80);
        // display on and off per chip
        bus_access(OP_WRITE, 1'b1, RS_INSTR, INSTR_DISP_ON);
        bus_access(OP_READ,  1'b1, RS_INSTR, 8'h00);
        bus_access(OP_WRITE, 1'b0, RS_INSTR, INSTR_DISP_OFF);
        bus_access(OP_READ,  1'b0, RS_INSTR, 8'hFF);
        // first page and column
        bus_access(OP_WRITE, 1'b1, RS_INSTR, INSTR_PAGE_CODE);
        bus_access(OP_WRITE, 1'b1, RS_INSTR, INSTR_COL_CODE);

        // random part under three idle patterns
        random_accesses(PHASE_ACCESSES);
        src_idle_pct  = 58;
        sink_idle_pct = 36;
        random_accesses(PHASE_ACCESSES);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_accesses(PHASE_ACCESSES);
        cmd.valid <= 1'b0;

        // drain outstanding read words
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && words_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
